// ----- rtl/ukdq_pkg.sv -----
// Shared types and constants for the unique-key deque.
package ukdq_pkg;

  localparam int unsigned DepthDef   = 16;
  localparam int unsigned KeyBitsDef = 32;
  localparam int unsigned KeyInW     = 32;
  localparam int unsigned TotalW     = 5;

  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_BACK   = 2'd2,
    ACT_POP_FRONT  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_COMMIT,
    FSM_POP_RD,
    FSM_POP_WAIT
  } fsm_e;

  typedef struct packed {
    action_e                   action;
    logic signed [KeyInW-1:0]  key;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [KeyInW-1:0]  popped_key;
    logic [TotalW-1:0]         entry_total;
  } rsp_t;

endpackage

// ----- rtl/unique_key_deque_unit.sv -----
// Unique-key deque: bounded ring of keys in one RAM, duplicate search on every push.
// Push: the stored keys are read one per cycle and compared as they return; a match ends the
//   search with a duplicate result, else the commit state writes the key or reports full.
// Pop: POP_RD issues a registered RAM read and POP_WAIT returns the key; empty answers in POP_RD.
// busy drops in the strobe cycle, so the next request may start there; results cannot stall.
// Reset clears pointers and count at once; RAM contents are not cleared.
module unique_key_deque_unit #(
  parameter int unsigned DEPTH    = ukdq_pkg::DepthDef,
  parameter int unsigned KEY_BITS = ukdq_pkg::KeyBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ukdq_pkg::req_t req_i,
  output logic           done_o,
  output ukdq_pkg::rsp_t rsp_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ukdq_pkg::fsm_e    state_q, state_d;
  ukdq_pkg::action_e act_q, act_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [PW-1:0] front_q, front_d, back_q, back_d, scan_ptr_q, scan_ptr_d;
  logic [CW-1:0] fill_q, fill_d, issued_q, issued_d;
  logic          pend_q, pend_d;
  logic          done_q, done_d;
  ukdq_pkg::rsp_t rsp_q, rsp_d;

  logic [KEY_BITS-1:0] mem_q [DEPTH];
  logic [KEY_BITS-1:0] rd_data_q;
  logic                rd_en, wr_en;
  logic [PW-1:0]       rd_addr, wr_addr;

  logic accept, is_push, scan_issue, scan_hit, is_full, is_empty;
  logic [PW-1:0] back_prev, front_prev, front_next, back_next, scan_next;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  assign accept     = start && !busy;
  assign is_push    = (req_i.action == ukdq_pkg::ACT_PUSH_BACK) ||
                      (req_i.action == ukdq_pkg::ACT_PUSH_FRONT);
  assign is_full    = (fill_q == CW'(DEPTH));
  assign is_empty   = (fill_q == '0);
  assign scan_issue = (state_q == ukdq_pkg::FSM_SCAN) && (issued_q != fill_q);
  assign scan_hit   = pend_q && (rd_data_q == key_q);
  assign back_prev  = ring_prev(back_q);
  assign back_next  = ring_next(back_q);
  assign front_prev = ring_prev(front_q);
  assign front_next = ring_next(front_q);
  assign scan_next  = ring_next(scan_ptr_q);

  assign busy   = (state_q != ukdq_pkg::FSM_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ukdq_pkg::FSM_IDLE: begin
        if (accept) state_d = is_push ? ukdq_pkg::FSM_SCAN : ukdq_pkg::FSM_POP_RD;
      end
      ukdq_pkg::FSM_SCAN: begin
        if (scan_hit) state_d = ukdq_pkg::FSM_IDLE;
        else if (!scan_issue && !pend_q) state_d = ukdq_pkg::FSM_COMMIT;
      end
      ukdq_pkg::FSM_COMMIT:   state_d = ukdq_pkg::FSM_IDLE;
      ukdq_pkg::FSM_POP_RD:   state_d = is_empty ? ukdq_pkg::FSM_IDLE : ukdq_pkg::FSM_POP_WAIT;
      ukdq_pkg::FSM_POP_WAIT: state_d = ukdq_pkg::FSM_IDLE;
      default:                state_d = ukdq_pkg::FSM_IDLE;
    endcase
  end

  // RAM port controls
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_ptr_q;
    wr_en   = 1'b0;
    wr_addr = back_q;
    unique case (state_q)
      ukdq_pkg::FSM_SCAN: rd_en = scan_issue;
      ukdq_pkg::FSM_COMMIT: begin
        wr_en   = !is_full;
        wr_addr = (act_q == ukdq_pkg::ACT_PUSH_BACK) ? back_q : front_prev;
      end
      ukdq_pkg::FSM_POP_RD: begin
        rd_en   = !is_empty;
        rd_addr = (act_q == ukdq_pkg::ACT_POP_BACK) ? back_prev : front_q;
      end
      default: ;
    endcase
  end

  // datapath and result
  always_comb begin
    act_d      = act_q;
    key_d      = key_q;
    front_d    = front_q;
    back_d     = back_q;
    fill_d     = fill_q;
    scan_ptr_d = scan_ptr_q;
    issued_d   = issued_q;
    pend_d     = 1'b0;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    unique case (state_q)
      ukdq_pkg::FSM_IDLE: begin
        if (accept) begin
          act_d      = req_i.action;
          key_d      = KEY_BITS'(req_i.key);
          scan_ptr_d = front_q;
          issued_d   = '0;
        end
      end
      ukdq_pkg::FSM_SCAN: begin
        pend_d = scan_issue;
        if (scan_issue) begin
          scan_ptr_d = scan_next;
          issued_d   = issued_q + CW'(1);
        end
        if (scan_hit) begin
          done_d            = 1'b1;
          rsp_d.status      = ukdq_pkg::STAT_DUP;
          rsp_d.popped_key  = '0;
          rsp_d.entry_total = ukdq_pkg::TotalW'(fill_q);
        end
      end
      ukdq_pkg::FSM_COMMIT: begin
        done_d           = 1'b1;
        rsp_d.popped_key = '0;
        if (is_full) begin
          rsp_d.status      = ukdq_pkg::STAT_FULL;
          rsp_d.entry_total = ukdq_pkg::TotalW'(fill_q);
        end else begin
          if (act_q == ukdq_pkg::ACT_PUSH_BACK) back_d = back_next;
          else front_d = front_prev;
          fill_d            = fill_q + CW'(1);
          rsp_d.status      = ukdq_pkg::STAT_DONE;
          rsp_d.entry_total = ukdq_pkg::TotalW'(fill_q + CW'(1));
        end
      end
      ukdq_pkg::FSM_POP_RD: begin
        if (is_empty) begin
          done_d            = 1'b1;
          rsp_d.status      = ukdq_pkg::STAT_EMPTY;
          rsp_d.popped_key  = '0;
          rsp_d.entry_total = ukdq_pkg::TotalW'(fill_q);
        end else begin
          if (act_q == ukdq_pkg::ACT_POP_BACK) back_d = back_prev;
          else front_d = front_next;
          fill_d = fill_q - CW'(1);
        end
      end
      ukdq_pkg::FSM_POP_WAIT: begin
        // count was already lowered when the read went out
        done_d            = 1'b1;
        rsp_d.status      = ukdq_pkg::STAT_DONE;
        rsp_d.popped_key  = ukdq_pkg::KeyInW'(rd_data_q);
        rsp_d.entry_total = ukdq_pkg::TotalW'(fill_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ukdq_pkg::FSM_IDLE;
      front_q  <= '0;
      back_q   <= '0;
      fill_q   <= '0;
      issued_q <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      back_q   <= back_d;
      fill_q   <= fill_d;
      issued_q <= issued_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    key_q      <= key_d;
    scan_ptr_q <= scan_ptr_d;
    rsp_q      <= rsp_d;
  end

  // key RAM, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= key_q;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || fill_q == CW'(DEPTH)) |-> (front_q == back_q))
    else $error("ring pointers disagree with fill count");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ukdq_pkg::FSM_IDLE))
    else $error("result strobe while sequencer busy");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("RAM read and write in the same cycle");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request taken but sequencer not busy");

endmodule

// ----- dv/unique_key_deque_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the unique-key deque: directed corner cases, then random traffic.
module unique_key_deque_unit_tb;

  localparam int unsigned Depth = ukdq_pkg::DepthDef;

  typedef logic signed [ukdq_pkg::KeyInW-1:0] key_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done_o;
  ukdq_pkg::req_t req_i;
  ukdq_pkg::rsp_t rsp_o;

  key_t           held_keys[$];   // predicted deque contents, front first
  ukdq_pkg::rsp_t due_rsp_q[$];   // predicted results not yet seen
  int unsigned    mismatches;
  bit             idle_on;

  key_t key_pool[8] = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1,
                        32'sd1, 32'sd2, 32'sh55aa55aa, 32'shaa55aa55};

  unique_key_deque_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one request to the predicted deque and returns the result it should give.
  function automatic ukdq_pkg::rsp_t deque_outcome(input ukdq_pkg::req_t r);
    ukdq_pkg::rsp_t res;
    bit             found;
    res.status     = ukdq_pkg::STAT_DONE;
    res.popped_key = '0;
    found          = 1'b0;
    case (r.action)
      ukdq_pkg::ACT_PUSH_BACK, ukdq_pkg::ACT_PUSH_FRONT: begin
        foreach (held_keys[i]) begin
          if (held_keys[i] == r.key) found = 1'b1;
        end
        // search wins over the full check
        if (found) begin
          res.status = ukdq_pkg::STAT_DUP;
        end else if (held_keys.size() >= Depth) begin
          res.status = ukdq_pkg::STAT_FULL;
        end else if (r.action == ukdq_pkg::ACT_PUSH_BACK) begin
          held_keys.push_back(r.key);
        end else begin
          held_keys.push_front(r.key);
        end
      end
      default: begin
        if (held_keys.size() == 0) begin
          res.status = ukdq_pkg::STAT_EMPTY;
        end else if (r.action == ukdq_pkg::ACT_POP_BACK) begin
          res.popped_key = held_keys.pop_back();
        end else begin
          res.popped_key = held_keys.pop_front();
        end
      end
    endcase
    res.entry_total = ukdq_pkg::TotalW'(held_keys.size());
    return res;
  endfunction

  function automatic bit key_held(input key_t k);
    foreach (held_keys[i]) begin
      if (held_keys[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    do k = $urandom; while (key_held(k));
    return k;
  endfunction

  // start stays high across back-to-back requests unless a random gap, when enabled, lowers it
  task automatic send_request(input ukdq_pkg::action_e act, input key_t k);
    ukdq_pkg::req_t r;
    int             gap;
    r.action = act;
    r.key    = k;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 3);
      start     <= 1'b0;
      req_i.key <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    due_rsp_q.push_back(deque_outcome(r));
  endtask

  always @(posedge clk_i) begin
    ukdq_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (due_rsp_q.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: %p", rsp_o));
      end else begin
        want = due_rsp_q.pop_front();
        if (rsp_o.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", rsp_o.status, want.status));
        if (rsp_o.popped_key !== want.popped_key)
          flag_mismatch($sformatf("popped_key %h, want %h", rsp_o.popped_key,
                                  want.popped_key));
        if (rsp_o.entry_total !== want.entry_total)
          flag_mismatch($sformatf("entry_total %0d, want %0d", rsp_o.entry_total,
                                  want.entry_total));
      end
    end
  end

  task automatic test_empty_pops();
    send_request(ukdq_pkg::ACT_POP_BACK, $urandom);
    send_request(ukdq_pkg::ACT_POP_FRONT, $urandom);
  endtask

  task automatic test_extreme_keys();
    send_request(ukdq_pkg::ACT_PUSH_BACK, 32'sh7fffffff);
    send_request(ukdq_pkg::ACT_PUSH_FRONT, 32'sh80000000);
    send_request(ukdq_pkg::ACT_PUSH_BACK, 32'sh0);
    send_request(ukdq_pkg::ACT_PUSH_FRONT, -32'sd1);
  endtask

  task automatic test_duplicates();
    send_request(ukdq_pkg::ACT_PUSH_BACK, -32'sd1);
    send_request(ukdq_pkg::ACT_PUSH_FRONT, 32'sh7fffffff);
  endtask

  task automatic test_both_ends_pop();
    send_request(ukdq_pkg::ACT_POP_BACK, $urandom);
    send_request(ukdq_pkg::ACT_POP_FRONT, $urandom);
  endtask

  // fill to the brim, then a new key (full) and a held key (duplicate while full)
  task automatic test_full_store();
    while (held_keys.size() < Depth)
      send_request($urandom_range(1) ? ukdq_pkg::ACT_PUSH_FRONT : ukdq_pkg::ACT_PUSH_BACK,
                   fresh_key());
    send_request(ukdq_pkg::ACT_PUSH_BACK, fresh_key());
    send_request(ukdq_pkg::ACT_PUSH_FRONT, held_keys[$urandom_range(Depth - 1)]);
  endtask

  // push_pct steers the fill level; keys lean on a small pool and held keys for repeats
  task automatic test_random_mix(input int items, input int push_pct, input bit gaps);
    ukdq_pkg::action_e act;
    key_t              k;
    int                pick;
    idle_on = gaps;
    repeat (items) begin
      if ($urandom_range(99) < push_pct)
        act = $urandom_range(1) ? ukdq_pkg::ACT_PUSH_FRONT : ukdq_pkg::ACT_PUSH_BACK;
      else
        act = $urandom_range(1) ? ukdq_pkg::ACT_POP_FRONT : ukdq_pkg::ACT_POP_BACK;
      pick = $urandom_range(3);
      if (pick < 2)
        k = key_pool[$urandom_range(7)];
      else if (pick == 2 && held_keys.size() != 0)
        k = held_keys[$urandom_range(held_keys.size() - 1)];
      else
        k = $urandom;
      send_request(act, k);
    end
  endtask

  initial begin
    mismatches = 0;
    idle_on    = 1'b1;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pops();
    test_extreme_keys();
    test_duplicates();
    test_both_ends_pop();
    test_full_store();
    test_random_mix(450, 75, 1'b1);
    test_random_mix(400, 30, 1'b1);
    test_random_mix(350, 60, 1'b1);
    test_random_mix(300, 40, 1'b0);
    start <= 1'b0;

    for (int w = 0; w < 200 && due_rsp_q.size() != 0; w++) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    if (due_rsp_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", due_rsp_q.size()));

    if (mismatches == 0) begin
      $display("** unique_key_deque_unit: PASSED **");
    end else begin
      $display("** unique_key_deque_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("[%0t] timeout", $time);
    $display("** unique_key_deque_unit: FAILED **");
    $finish;
  end

endmodule
